>>> sv/sgb_pkg.sv
// shared constants, types and helper functions of the separable gaussian blur
package sgb_pkg;

  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int LINE_ROWS   = 8;
  localparam int LR_W        = $clog2(LINE_ROWS);
  localparam int NTAPS       = 7;
  localparam int NTAPS5      = 5;
  localparam int VSUM_W      = 14;
  localparam int HSUM_W      = 22;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MODE  = 2'd2;

  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd1024;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam logic MODE_5X5 = 1'b0;
  localparam logic MODE_7X7 = 1'b1;

  typedef logic [7:0] pixel_t;
  typedef logic [4:0] tap_t;

  localparam tap_t TAPS5 [NTAPS] = '{5'd1, 5'd4, 5'd6, 5'd4, 5'd1, 5'd0, 5'd0};
  localparam tap_t TAPS7 [NTAPS] = '{5'd1, 5'd6, 5'd15, 5'd20, 5'd15, 5'd6, 5'd1};

  // binomial weight of tap j for the selected kernel
  function automatic tap_t tap(logic mode, int j);
    tap_t t;
    t = (mode == MODE_7X7) ? TAPS7[j] : TAPS5[j];
    return t;
  endfunction

  // reflect-101 border; idx lies within three of the range, so one bounce
  // suffices except for sizes below four
  function automatic int mirror(int idx, int size);
    int m;
    m = idx;
    if (size <= 1) begin
      m = 0;
    end else if (size == 2) begin
      m = idx & 1;
    end else if (size == 3) begin
      m = idx & 3;
      if (m == 3) m = 1;
    end else if (idx < 0) begin
      m = -idx;
    end else if (idx >= size) begin
      m = 2 * size - 2 - idx;
    end
    return m;
  endfunction

endpackage

>>> sv/sgb_if.sv
// stream channels of the blur: source pixels in, blurred pixels out
interface sgb_pix_in_if;
  logic         valid;
  logic         ready;
  logic         kind;
  logic [7:0]   pixel_in;
  modport source (output valid, kind, pixel_in, input ready);
  modport sink   (input valid, kind, pixel_in, output ready);
endinterface

interface sgb_pix_out_if;
  logic         valid;
  logic         ready;
  logic [7:0]   pixel_out;
  logic         frame_last;
  modport source (output valid, pixel_out, frame_last, input ready);
  modport sink   (input valid, pixel_out, frame_last, output ready);
endinterface

>>> sv/sgb_line_store.sv
// line store: one bank per buffered row, all banks read at the same column
module sgb_line_store #(
  parameter int MAX_WIDTH = sgb_pkg::DEF_MAX_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [sgb_pkg::LR_W-1:0]             wbank_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]         waddr_i,
  input  sgb_pkg::pixel_t                      wdata_i,
  input  logic                                 re_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]         raddr_i,
  output sgb_pkg::pixel_t [sgb_pkg::LINE_ROWS-1:0] rdata_o
);
  import sgb_pkg::*;

  for (genvar b = 0; b < LINE_ROWS; b++) begin : g_bank
    pixel_t mem [MAX_WIDTH];
    pixel_t rd_q;

    always_ff @(posedge clk_i) begin
      if (we_i && (wbank_i == LR_W'(b))) begin
        mem[waddr_i] <= wdata_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (re_i) begin
        rd_q <= mem[raddr_i];
      end
    end

    assign rdata_o[b] = rd_q;
  end

endmodule

>>> sv/separable_gaussian_blur.sv
// top level: streaming separable binomial blur, 5x5 or 7x7, reflect-101 borders
// throughput one transfer per cycle in and out while out_o.ready holds; an accepted item's
// result reaches the output register through the line store read, the vertical sum and the
// horizontal sum; results appear r*width+r items after the matching source pixel
// reset (async, active low) clears control and the frame position and loads
// width 1024, height 1024, 5x5 mode; line store contents stay undefined
module separable_gaussian_blur #(
  parameter int MAX_WIDTH  = sgb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  sgb_pix_in_if.sink                        in_i,
  sgb_pix_out_if.source                     out_o,
  input  logic                              cfg_we_i,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sgb_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import sgb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);       // column index
  localparam int XW = $clog2(MAX_WIDTH + 1);   // width value
  localparam int HW = $clog2(MAX_HEIGHT + 1);  // height value and output row
  localparam int RW = HW + 1;                  // input row, runs past the frame in the tail
  localparam int LW = XW + 2;                  // lag r*w+r
  localparam int OW = 3;                       // window offset 0..6

  // configuration registers
  logic [10:0] width_q;
  logic [12:0] height_q;
  logic        mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
      mode_q   <= MODE_5X5;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[10:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        CFG_KERNEL_MODE:  mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // only known register indexes restart the frame
  logic cfg_restart;
  assign cfg_restart = cfg_we_i && ((cfg_idx_i == CFG_IMAGE_WIDTH) ||
                       (cfg_idx_i == CFG_IMAGE_HEIGHT) || (cfg_idx_i == CFG_KERNEL_MODE));

  // effective dimensions: zero counts as one, too large counts as the maximum
  logic [XW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [1:0]    radius;
  logic [LW-1:0] lag;

  always_comb begin
    if (width_q == '0) begin
      w_eff = XW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = XW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_q);
    end
    radius = (mode_q == MODE_7X7) ? 2'd3 : 2'd2;
    // r*w as shift and add
    lag = (mode_q == MODE_7X7) ? (LW'(w_eff) << 1) + LW'(w_eff) + LW'(3)
                               : (LW'(w_eff) << 1) + LW'(2);
  end

  // pipeline handshake: each stage moves when the one after it has room
  logic s1_v_q, s2_v_q, out_v_q;
  logic s2_out_q;
  logic out_free, s2_go, en2, s1_go, en1, in_fire;

  assign out_free = !out_v_q || out_o.ready;
  assign s2_go    = s2_v_q && (!s2_out_q || out_free);
  assign en2      = !s2_v_q || s2_go;
  assign s1_go    = s1_v_q && en2;
  assign en1      = !s1_v_q || s1_go;
  assign in_i.ready = en1;
  assign in_fire  = in_i.valid && en1;

  // frame position of the next item and the output position
  logic [CW-1:0] ix_q;
  logic [RW-1:0] iy_q;
  logic          tail_q;
  logic [LW-1:0] lc_q;     // items seen before the first result
  logic [CW-1:0] ox_q;
  logic [HW-1:0] oy_q;

  logic step, wr_pix, has_out, last_out, col_wrap, out_col_wrap;

  // a drain before the tail is taken and dropped; a pixel in the tail is a drain
  assign step     = in_fire && (tail_q || (in_i.kind == KIND_PIXEL));
  assign wr_pix   = in_fire && !tail_q && (in_i.kind == KIND_PIXEL);
  assign has_out  = (lc_q == lag);
  assign col_wrap = ({1'b0, ix_q} == XW'(w_eff - XW'(1)));
  assign out_col_wrap = ({1'b0, ox_q} == XW'(w_eff - XW'(1)));
  assign last_out = has_out && out_col_wrap && (oy_q == HW'(h_eff - HW'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ix_q   <= '0;
      iy_q   <= '0;
      tail_q <= 1'b0;
      lc_q   <= '0;
      ox_q   <= '0;
      oy_q   <= '0;
    end else if (cfg_restart || (step && last_out)) begin
      ix_q   <= '0;
      iy_q   <= '0;
      tail_q <= 1'b0;
      lc_q   <= '0;
      ox_q   <= '0;
      oy_q   <= '0;
    end else if (step) begin
      if (col_wrap) begin
        ix_q <= '0;
        iy_q <= iy_q + RW'(1);
      end else begin
        ix_q <= ix_q + CW'(1);
      end
      // last source pixel of the frame opens the tail
      if (wr_pix && col_wrap && (iy_q == RW'(h_eff - HW'(1)))) begin
        tail_q <= 1'b1;
      end
      if (!has_out) begin
        lc_q <= lc_q + LW'(1);
      end else if (out_col_wrap) begin
        ox_q <= '0;
        oy_q <= oy_q + HW'(1);
      end else begin
        ox_q <= ox_q + CW'(1);
      end
    end
  end

  // line store: source row iy lands in bank iy mod LINE_ROWS at column ix;
  // every bank is read at column ix for the vertical sum of row iy-r
  pixel_t [LINE_ROWS-1:0] rd_data;

  sgb_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (wr_pix),
    .wbank_i (iy_q[LR_W-1:0]),
    .waddr_i (ix_q),
    .wdata_i (in_i.pixel_in),
    .re_i    (in_fire),
    .raddr_i (ix_q),
    .rdata_o (rd_data)
  );

  // per tap: which bank holds the mirrored row, and the offset back into the
  // column sum window of the mirrored column (offset 0 is the newest sum)
  logic [LR_W-1:0] rbank [NTAPS];
  logic [OW-1:0]   coff  [NTAPS];

  always_comb begin
    int row;
    int col;
    for (int j = 0; j < NTAPS; j++) begin
      row = mirror(int'(iy_q) - 2 * int'(radius) + j, int'(h_eff));
      rbank[j] = row[LR_W-1:0];
      col = mirror(int'(ox_q) + j - int'(radius), int'(w_eff));
      coff[j] = OW'(int'(ox_q) + int'(radius) - col);
    end
  end

  // stage 1: read data registered in the line store, vertical pass
  pixel_t          s1_pix_q;
  logic            s1_fwd_q;
  logic [LR_W-1:0] s1_cur_q;
  logic [LR_W-1:0] s1_rbank_q [NTAPS];
  logic [OW-1:0]   s1_off_q   [NTAPS];
  logic            s1_mode_q, s1_out_q, s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en1) begin
      s1_v_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q   <= in_i.pixel_in;
      s1_fwd_q   <= wr_pix;
      s1_cur_q   <= iy_q[LR_W-1:0];
      s1_rbank_q <= rbank;
      s1_off_q   <= coff;
      s1_mode_q  <= mode_q;
      s1_out_q   <= has_out;
      s1_last_q  <= last_out;
    end
  end

  // the current row is being written this very transfer, so its pixel bypasses
  pixel_t [LINE_ROWS-1:0] rows_fw;
  logic [VSUM_W-1:0]      vsum;

  always_comb begin
    rows_fw = rd_data;
    if (s1_fwd_q) begin
      rows_fw[s1_cur_q] = s1_pix_q;
    end
    vsum = '0;
    // the 5x5 kernel only touches the first five taps
    for (int j = 0; j < NTAPS; j++) begin
      if ((s1_mode_q == MODE_7X7) || (j < NTAPS5)) begin
        vsum = vsum + VSUM_W'(rows_fw[s1_rbank_q[j]] * tap(s1_mode_q, j));
      end
    end
  end

  // stage 2: column sum window of the last seven vertical sums, horizontal pass
  logic [VSUM_W-1:0] vs_q [NTAPS];
  logic [OW-1:0]     s2_off_q [NTAPS];
  logic              s2_mode_q, s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q   <= 1'b0;
      s2_out_q <= 1'b0;
    end else if (en2) begin
      s2_v_q   <= s1_v_q;
      s2_out_q <= s1_v_q && s1_out_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      vs_q[0] <= vsum;
      for (int i = 1; i < NTAPS; i++) begin
        vs_q[i] <= vs_q[i-1];
      end
      s2_off_q  <= s1_off_q;
      s2_mode_q <= s1_mode_q;
      s2_last_q <= s1_last_q;
    end
  end

  logic [HSUM_W-1:0] hsum, hrnd;
  pixel_t            blur;

  always_comb begin
    hsum = '0;
    for (int k = 0; k < NTAPS; k++) begin
      if ((s2_mode_q == MODE_7X7) || (k < NTAPS5)) begin
        hsum = hsum + HSUM_W'(vs_q[s2_off_q[k]] * tap(s2_mode_q, k));
      end
    end
    // round half up, then drop the kernel gain
    if (s2_mode_q == MODE_7X7) begin
      hrnd = hsum + HSUM_W'(2048);
      blur = hrnd[19:12];
    end else begin
      hrnd = hsum + HSUM_W'(128);
      blur = hrnd[15:8];
    end
  end

  // output register
  pixel_t out_pix_q;
  logic   out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s2_go && s2_out_q) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go && s2_out_q) begin
      out_pix_q  <= blur;
      out_last_q <= s2_last_q;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.pixel_out  = out_pix_q;
  assign out_o.frame_last = out_last_q;

endmodule
